// ===== hdl/csg_pkg.sv =====
// Shared types and constants for the circle span generator.
`default_nettype none
package csg_pkg;

  localparam int COORD_W     = 15;
  localparam int RADIUS_W    = 7;
  localparam int OUT_W       = 16;
  localparam int MAX_RADIUS  = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [RADIUS_W-1:0] radius;
    logic                mode;
  } circle_t;

endpackage
`default_nettype wire

// ===== hdl/csg_front.sv =====
// Input stage: clamps the radius and drops zero-radius circles.
`default_nettype none
module csg_front
  import csg_pkg::*;
#(
  parameter int MaxRadius = MAX_RADIUS
) (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [COORD_W-1:0]  center_x,
  input  wire logic [COORD_W-1:0]  center_y,
  input  wire logic [RADIUS_W-1:0] circle_radius,
  input  wire logic                hole_mode,
  input  wire logic                q_full,
  output logic                     push,
  output circle_t                  push_data
);

  localparam logic [RADIUS_W-1:0] RadLimit = RADIUS_W'(MaxRadius);

  logic [RADIUS_W-1:0] rad_sat;

  always_comb begin
    rad_sat = (circle_radius > RadLimit) ? RadLimit : circle_radius;
    in_ready = !q_full;
    push = in_valid && !q_full && (rad_sat != '0);
    push_data.cx = center_x;
    push_data.cy = center_y;
    push_data.radius = rad_sat;
    push_data.mode = hole_mode;
  end

endmodule
`default_nettype wire

// ===== hdl/csg_queue.sv =====
// Short circle queue between the front and back stages.
`default_nettype none
module csg_queue
  import csg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire circle_t push_data,
  input  wire logic    pop,
  output circle_t      pop_data,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(QUEUE_DEPTH - 1);

  circle_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == DepthCnt);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/csg_back.sv =====
// Row sequencer: per row, one multiply, a bit-serial square root, then output.
`default_nettype none
module csg_back
  import csg_pkg::*;
#(
  parameter int MaxRadius = MAX_RADIUS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire circle_t           q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       upper_row,
  output logic [OUT_W-1:0]       lower_row,
  output logic                   lower_valid,
  output logic [OUT_W-1:0]       inner_left,
  output logic [OUT_W-1:0]       inner_right,
  output logic [OUT_W-1:0]       outer_left,
  output logic [OUT_W-1:0]       outer_right,
  output logic                   row_mode,
  output logic                   last_row
);

  localparam int ROOT_W = $clog2(MaxRadius + 1);
  localparam int ARG_W  = 2 * ROOT_W;
  localparam int CNT_W  = $clog2(ROOT_W + 1);
  localparam int PROD_W = 2 * RADIUS_W + 2;
  localparam logic [ARG_W-1:0] BitInit = ARG_W'(1) << (ARG_W - 2);
  localparam logic [CNT_W-1:0] StepsM1 = CNT_W'(ROOT_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ARG  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state;
  circle_t             held;
  logic [RADIUS_W-1:0] dy;
  logic [ARG_W-1:0]    rem;
  logic [ARG_W-1:0]    root;
  logic [ARG_W-1:0]    sq_bit;
  logic [CNT_W-1:0]    step;

  logic [RADIUS_W:0]   twice_minus;
  logic [PROD_W-1:0]   product;
  logic [ARG_W:0]      trial;
  logic [OUT_W-1:0]    cx16;
  logic [OUT_W-1:0]    cy16;
  logic [OUT_W-1:0]    dy16;
  logic [OUT_W-1:0]    r16;
  logic [OUT_W-1:0]    dx16;
  logic                emit_go;

  always_comb begin
    twice_minus = {held.radius, 1'b0} - {1'b0, dy};
    product     = PROD_W'({1'b0, dy}) * PROD_W'(twice_minus);
    trial       = {1'b0, root} + {1'b0, sq_bit};
    cx16 = {held.cx[COORD_W-1], held.cx};
    cy16 = {held.cy[COORD_W-1], held.cy};
    dy16 = OUT_W'(dy);
    r16  = OUT_W'(held.radius);
    dx16 = OUT_W'(root[ROOT_W-1:0]);
    emit_go = (state == ST_EMIT) && (!out_valid || out_ready);
    q_pop = (state == ST_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_ARG;
          end
        end
        ST_ARG:  state <= ST_SQRT;
        ST_SQRT: begin
          if (step == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= (dy == held.radius) ? ST_IDLE : ST_ARG;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        held <= q_data;
        dy   <= RADIUS_W'(1);
      end
      ST_ARG: begin
        rem    <= ARG_W'(product);
        root   <= '0;
        sq_bit <= BitInit;
        step   <= StepsM1;
      end
      ST_SQRT: begin
        if ({1'b0, rem} >= trial) begin
          rem  <= rem - trial[ARG_W-1:0];
          root <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
        sq_bit <= sq_bit >> 2;
        step   <= step - 1'b1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          upper_row   <= cy16 + dy16 - r16;
          lower_row   <= cy16 - dy16 + r16;
          lower_valid <= (dy < held.radius);
          inner_left  <= cx16 - dx16;
          inner_right <= cx16 + dx16;
          outer_left  <= cx16 - r16;
          outer_right <= cx16 + r16;
          row_mode    <= held.mode;
          last_row    <= (dy == held.radius);
          dy          <= dy + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/circle_span_generator_core.sv =====
// Circle span generator top level: front stage, circle queue, row sequencer.
//
// Input channel (in_valid/in_ready) takes one circle: center_x, center_y,
// circle_radius, hole_mode. Radii above MaxRadius clamp to MaxRadius; a zero
// radius is accepted and produces nothing.
// Output channel (out_valid/out_ready) gives one row record per dy = 1..r,
// in order, with last_row set on the final record of each circle.
// Each row runs a multiply step, a bit-serial square root of one result
// bit per cycle, and an output load; each circle is first pulled from the
// queue. The square-root unit sets the rate.
// A two-entry queue lets the input take up to two further circles while
// the sequencer works or the output stalls; in_ready drops when it fills.
// When the receiver holds out_ready low, the record stays in the output
// register and the sequencer waits before loading the next one.
// Reset (rst, synchronous) empties the queue, idles the sequencer and
// clears out_valid.
`default_nettype none
module circle_span_generator_core
  import csg_pkg::*;
#(
  parameter int MaxRadius = MAX_RADIUS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [COORD_W-1:0]  center_x,
  input  wire logic [COORD_W-1:0]  center_y,
  input  wire logic [RADIUS_W-1:0] circle_radius,
  input  wire logic                hole_mode,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_W-1:0]         upper_row,
  output logic [OUT_W-1:0]         lower_row,
  output logic                     lower_valid,
  output logic [OUT_W-1:0]         inner_left,
  output logic [OUT_W-1:0]         inner_right,
  output logic [OUT_W-1:0]         outer_left,
  output logic [OUT_W-1:0]         outer_right,
  output logic                     row_mode,
  output logic                     last_row
);

  circle_t push_data;
  circle_t pop_data;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;

  csg_front #(.MaxRadius(MaxRadius)) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .hole_mode     (hole_mode),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  csg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  csg_back #(.MaxRadius(MaxRadius)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .upper_row   (upper_row),
    .lower_row   (lower_row),
    .lower_valid (lower_valid),
    .inner_left  (inner_left),
    .inner_right (inner_right),
    .outer_left  (outer_left),
    .outer_right (outer_right),
    .row_mode    (row_mode),
    .last_row    (last_row)
  );

  a_last_no_lower: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> !lower_valid)
    else $error("last row record flags a mirrored row");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("sequencer pulls from an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
